// ===== rtl/core/dpsc_pkg.sv =====
// dpsc_pkg: types, codes and decode functions of the drive power state control block
// no dependencies; used by the channel interfaces and the core

package dpsc_pkg;

    // power states as reported on the result channel
    typedef enum logic [2:0] {
        PS_NOT_READY      = 3'd0,
        PS_SO_DISABLED    = 3'd1,
        PS_READY          = 3'd2,
        PS_SWITCHED_ON    = 3'd3,
        PS_ENABLED        = 3'd4,
        PS_QUICKSTOP      = 3'd5,
        PS_FAULT_REACTION = 3'd6,
        PS_FAULT          = 3'd7
    } power_state_t;

    // target power requests
    localparam logic [1:0] TGT_DISABLED  = 2'd0;
    localparam logic [1:0] TGT_ENABLED   = 2'd1;
    localparam logic [1:0] TGT_QUICKSTOP = 2'd2;

    // control word command nibbles
    localparam logic [3:0] CMD_NONE            = 4'b0000;
    localparam logic [3:0] CMD_SHUTDOWN        = 4'b0110;
    localparam logic [3:0] CMD_DISABLE_VOLTAGE = 4'b0100;
    localparam logic [3:0] CMD_ENABLE_OP       = 4'b1111;
    localparam logic [3:0] CMD_SWITCH_ON       = 4'b0111;
    localparam logic [3:0] CMD_QUICKSTOP       = 4'b0010;

    localparam int FAULT_RESET_BIT = 7;

    localparam logic [3:0] MODE_NONE     = 4'd0;
    localparam logic [3:0] MODE_LAST_LOW = 4'd4;
    localparam logic [3:0] MODE_LAST     = 4'd10;
    localparam logic [7:0] CODE_GAP      = 8'd5;
    localparam logic [7:0] CODE_LAST     = 8'd11;

    typedef struct packed {
        logic        [15:0] status_word;
        logic signed [7:0]  mode_display_code;
        logic        [1:0]  target_power;
        logic               fault_reset_request;
        logic        [3:0]  target_mode;
        logic        [8:0]  extra_control_bits;
    } item_t;

    typedef struct packed {
        logic [15:0] control_word;
        logic [3:0]  mode_select_code;
        logic [2:0]  power_state;
        logic        power_state_changed;
        logic [3:0]  actual_mode;
        logic        has_fault;
        logic        has_warning;
        logic        voltage_enabled;
        logic        remote_active;
        logic        internal_limit;
        logic [5:0]  specific_status_bits;
    } result_t;

    function automatic power_state_t decode_power(input logic [15:0] sw);
        power_state_t ps;
        if (sw[3] && !(sw[0] && sw[1] && sw[2])) ps = PS_FAULT;
        else if (sw[3])                          ps = PS_FAULT_REACTION;
        else if (sw[6])                          ps = PS_SO_DISABLED;
        else if (!sw[5])                         ps = PS_QUICKSTOP;
        else if (sw[2])                          ps = PS_ENABLED;
        else if (sw[1])                          ps = PS_SWITCHED_ON;
        else if (sw[0])                          ps = PS_READY;
        else                                     ps = PS_NOT_READY;
        return ps;
    endfunction

    function automatic logic [3:0] command_bits(input logic [1:0] tgt, input power_state_t ps);
        logic [3:0] cmd;
        cmd = CMD_NONE;
        unique case (tgt)
            TGT_DISABLED:
            begin
                if (ps == PS_ENABLED || ps == PS_SWITCHED_ON || ps == PS_SO_DISABLED ||
                    ps == PS_READY || ps == PS_QUICKSTOP)
                    cmd = CMD_SHUTDOWN;
                else
                    cmd = CMD_DISABLE_VOLTAGE;
            end
            TGT_ENABLED:
            begin
                if (ps == PS_SWITCHED_ON || ps == PS_QUICKSTOP || ps == PS_ENABLED)
                    cmd = CMD_ENABLE_OP;
                else if (ps == PS_READY)
                    cmd = CMD_SWITCH_ON;
                else
                    cmd = CMD_SHUTDOWN;
            end
            TGT_QUICKSTOP:
            begin
                if (ps == PS_ENABLED || ps == PS_QUICKSTOP)
                    cmd = CMD_QUICKSTOP;
                else
                    cmd = CMD_SHUTDOWN;
            end
            default:
                cmd = CMD_NONE;
        endcase
        return cmd;
    endfunction

    // mode index to drive code: code five is skipped
    function automatic logic [3:0] mode_to_code(input logic [3:0] idx);
        logic [3:0] code;
        if (idx <= MODE_LAST_LOW)  code = idx;
        else if (idx <= MODE_LAST) code = idx + 4'd1;
        else                       code = MODE_NONE;
        return code;
    endfunction

    function automatic logic [3:0] code_to_mode(input logic signed [7:0] code);
        logic [7:0] c;
        logic [3:0] idx;
        c = code;
        if (c[7])                              idx = MODE_NONE;
        else if (c < CODE_GAP)                 idx = c[3:0];
        else if (c > CODE_GAP && c <= CODE_LAST) idx = c[3:0] - 4'd1;
        else                                   idx = MODE_NONE;
        return idx;
    endfunction

endpackage

// ===== rtl/core/dpsc_in_if.sv =====
// dpsc_in_if: valid/ready channel carrying one status item into the core
// depends on dpsc_pkg for the payload type

interface dpsc_in_if;
    logic           valid;
    logic           ready;
    dpsc_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/dpsc_out_if.sv =====
// dpsc_out_if: valid/ready channel carrying one control result out of the core
// depends on dpsc_pkg for the payload type

interface dpsc_out_if;
    logic             valid;
    logic             ready;
    dpsc_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/drive_power_state_control_core.sv =====
// an accepted item beat reaches its result beat through the input register, then the
// result register; throughput: one item per clock while results are taken
// the only loop is the one-bit fault-reset pending/busy flags and the last-state register
// reset: asynchronous, clears valid flags, fault-reset pending/busy and last power state
// depends on dpsc_pkg, dpsc_in_if, dpsc_out_if

module drive_power_state_control_core (
    input  logic           clk,
    input  logic           rst_n,
    dpsc_in_if.sink        item,
    dpsc_out_if.source     result
);

    logic                    in_valid_reg;
    dpsc_pkg::item_t         in_reg;
    logic                    out_valid_reg;
    dpsc_pkg::result_t       result_reg;
    logic                    reset_pending_reg;
    logic                    reset_busy_reg;
    dpsc_pkg::power_state_t  last_power_state_reg;

    logic                    advance;
    logic                    pending_eff;
    logic                    pulse;
    logic                    reset_pending_next;
    logic                    reset_busy_next;
    dpsc_pkg::power_state_t  ps;
    logic [3:0]              cmd;
    dpsc_pkg::result_t       result_next;

    // the held item moves on when the result slot is free or being emptied
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    assign result.valid = out_valid_reg;
    assign result.data  = result_reg;

    always_comb
    begin
        ps                 = dpsc_pkg::decode_power(in_reg.status_word);
        cmd                = dpsc_pkg::command_bits(in_reg.target_power, ps);
        pending_eff        = reset_pending_reg || in_reg.fault_reset_request;
        pulse              = pending_eff && !reset_busy_reg;
        reset_pending_next = pending_eff && !pulse;
        reset_busy_next    = pulse;

        result_next.control_word = {in_reg.extra_control_bits[8:4], 1'b0,
                                    in_reg.extra_control_bits[3], 1'b0, pulse,
                                    in_reg.extra_control_bits[2:0], cmd};
        result_next.mode_select_code    = dpsc_pkg::mode_to_code(in_reg.target_mode);
        result_next.power_state         = ps;
        result_next.power_state_changed = (ps != last_power_state_reg);
        result_next.actual_mode         = dpsc_pkg::code_to_mode(in_reg.mode_display_code);
        result_next.has_fault           = in_reg.status_word[3];
        result_next.has_warning         = in_reg.status_word[7];
        result_next.voltage_enabled     = in_reg.status_word[4];
        result_next.remote_active       = in_reg.status_word[9];
        result_next.internal_limit      = in_reg.status_word[11];
        result_next.specific_status_bits = {in_reg.status_word[15:12],
                                            in_reg.status_word[10], in_reg.status_word[8]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            reset_pending_reg    <= 1'b0;
            reset_busy_reg       <= 1'b0;
            last_power_state_reg <= dpsc_pkg::PS_NOT_READY;
        end
        else
        begin
            if (item.ready)
                in_valid_reg <= item.valid;
            if (advance)
            begin
                out_valid_reg        <= 1'b1;
                reset_pending_reg    <= reset_pending_next;
                reset_busy_reg       <= reset_busy_next;
                last_power_state_reg <= ps;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            in_reg <= item.data;
        if (advance)
            result_reg <= result_next;
    end

    // a busy cycle never carries a fault-reset pulse
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && reset_busy_reg)
        |=> !result_reg.control_word[dpsc_pkg::FAULT_RESET_BIT])
        else $error("fault reset pulse issued during busy cycle");

    // every pulse is followed by a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && pulse) |=> (reset_busy_reg && !reset_pending_reg))
        else $error("fault reset pulse not followed by busy");

    // last power state follows the result being shown
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.power_state == last_power_state_reg))
        else $error("last power state out of step with result");

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for drive_power_state_control_core: directed table, then random status traffic
// under several idle and stall mixes, each result beat checked against a typed row or a local predictor
// depends on dpsc_pkg, dpsc_in_if, dpsc_out_if and the core

module testbench;

    // fourth target code: no command bits at all
    localparam logic [1:0] TGT_HOLD = 2'd3;

    typedef struct {
        dpsc_pkg::item_t   it;
        bit                typed;
        dpsc_pkg::result_t res;
    } stim_t;

    logic clk;
    logic rst_n;

    dpsc_in_if  item_ch ();
    dpsc_out_if result_ch ();

    drive_power_state_control_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // predictor state
    logic                   fr_armed    = 1'b0;
    logic                   fr_cooldown = 1'b0;
    dpsc_pkg::power_state_t prev_state  = dpsc_pkg::PS_NOT_READY;

    dpsc_pkg::result_t ctrl_expect_q[$];
    stim_t             stim_table[$];

    int mismatches     = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int pulses_seen    = 0;
    int changes_seen   = 0;
    logic [7:0] states_reached = '0;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    bit   hold_request   = 1'b0;
    int   hold_left      = 0;
    logic [15:0] last_gen_sw = '0;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic dpsc_pkg::result_t predict_control(input dpsc_pkg::item_t it);
        dpsc_pkg::result_t      r;
        dpsc_pkg::power_state_t ps;
        logic [15:0]            sw;
        logic [7:0]             mc;
        sw = it.status_word;
        r  = '0;

        // fault dominates, then switch-on disabled, then quick stop (active low)
        if (sw[3])
            ps = (&sw[2:0]) ? dpsc_pkg::PS_FAULT_REACTION : dpsc_pkg::PS_FAULT;
        else if (sw[6])
            ps = dpsc_pkg::PS_SO_DISABLED;
        else if (!sw[5])
            ps = dpsc_pkg::PS_QUICKSTOP;
        else if (sw[2])
            ps = dpsc_pkg::PS_ENABLED;
        else if (sw[1])
            ps = dpsc_pkg::PS_SWITCHED_ON;
        else if (sw[0])
            ps = dpsc_pkg::PS_READY;
        else
            ps = dpsc_pkg::PS_NOT_READY;

        r.power_state         = ps;
        r.power_state_changed = (ps != prev_state);
        prev_state            = ps;

        // request latches; a pulse is always followed by one quiet beat
        if (it.fault_reset_request)
            fr_armed = 1'b1;
        if (fr_armed && !fr_cooldown)
        begin
            r.control_word[dpsc_pkg::FAULT_RESET_BIT] = 1'b1;
            fr_cooldown = 1'b1;
            fr_armed    = 1'b0;
        end
        else
            fr_cooldown = 1'b0;

        unique case (it.target_power)
            dpsc_pkg::TGT_DISABLED:
                r.control_word[3:0] = (ps inside {dpsc_pkg::PS_NOT_READY,
                                                  dpsc_pkg::PS_FAULT_REACTION,
                                                  dpsc_pkg::PS_FAULT})
                                      ? dpsc_pkg::CMD_DISABLE_VOLTAGE
                                      : dpsc_pkg::CMD_SHUTDOWN;
            dpsc_pkg::TGT_ENABLED:
                if (ps inside {dpsc_pkg::PS_SWITCHED_ON, dpsc_pkg::PS_QUICKSTOP,
                               dpsc_pkg::PS_ENABLED})
                    r.control_word[3:0] = dpsc_pkg::CMD_ENABLE_OP;
                else if (ps == dpsc_pkg::PS_READY)
                    r.control_word[3:0] = dpsc_pkg::CMD_SWITCH_ON;
                else
                    r.control_word[3:0] = dpsc_pkg::CMD_SHUTDOWN;
            dpsc_pkg::TGT_QUICKSTOP:
                r.control_word[3:0] = (ps inside {dpsc_pkg::PS_ENABLED, dpsc_pkg::PS_QUICKSTOP})
                                      ? dpsc_pkg::CMD_QUICKSTOP : dpsc_pkg::CMD_SHUTDOWN;
            default:
                r.control_word[3:0] = dpsc_pkg::CMD_NONE;
        endcase

        r.control_word[6:4]   = it.extra_control_bits[2:0];
        r.control_word[9]     = it.extra_control_bits[3];
        r.control_word[15:11] = it.extra_control_bits[8:4];

        // drive mode codes skip five
        if (it.target_mode <= 4'd4)
            r.mode_select_code = it.target_mode;
        else if (it.target_mode <= 4'd10)
            r.mode_select_code = it.target_mode + 4'd1;
        else
            r.mode_select_code = dpsc_pkg::MODE_NONE;

        mc = it.mode_display_code;
        if (mc[7] || mc == 8'd5 || mc > 8'd11)
            r.actual_mode = dpsc_pkg::MODE_NONE;
        else if (mc < 8'd5)
            r.actual_mode = mc[3:0];
        else
            r.actual_mode = mc[3:0] - 4'd1;

        r.has_fault            = sw[3];
        r.has_warning          = sw[7];
        r.voltage_enabled      = sw[4];
        r.remote_active        = sw[9];
        r.internal_limit       = sw[11];
        r.specific_status_bits = {sw[15:12], sw[10], sw[8]};
        return r;
    endfunction

    function automatic dpsc_pkg::item_t mk_item(input logic [15:0] sw, input logic [7:0] md,
                                                input logic [1:0] tp, input logic fr,
                                                input logic [3:0] tm, input logic [8:0] ex);
        dpsc_pkg::item_t it;
        it.status_word         = sw;
        it.mode_display_code   = md;
        it.target_power        = tp;
        it.fault_reset_request = fr;
        it.target_mode         = tm;
        it.extra_control_bits  = ex;
        return it;
    endfunction

    function automatic dpsc_pkg::result_t mk_res(input logic [15:0] cw,
                                                 input logic [3:0] msel,
                                                 input dpsc_pkg::power_state_t ps,
                                                 input logic chg,
                                                 input logic [3:0] am, input logic [4:0] flags,
                                                 input logic [5:0] spec);
        dpsc_pkg::result_t r;
        r.control_word         = cw;
        r.mode_select_code     = msel;
        r.power_state          = ps;
        r.power_state_changed  = chg;
        r.actual_mode          = am;
        {r.has_fault, r.has_warning, r.voltage_enabled, r.remote_active,
         r.internal_limit}     = flags;
        r.specific_status_bits = spec;
        return r;
    endfunction

    task automatic add_row(input dpsc_pkg::item_t it, input bit typed,
                           input dpsc_pkg::result_t res);
        stim_t s;
        s.it    = it;
        s.typed = typed;
        s.res   = res;
        stim_table.push_back(s);
    endtask

    task automatic send_item(input stim_t s);
        dpsc_pkg::result_t want;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid = 1'b1;
        item_ch.data  = s.it;
        do
            @(posedge clk);
        while (!item_ch.ready);
        want = predict_control(s.it);
        if (s.typed)
            want = s.res;
        ctrl_expect_q.push_back(want);
        items_sent++;
        pulses_seen  += want.control_word[dpsc_pkg::FAULT_RESET_BIT];
        changes_seen += want.power_state_changed;
        states_reached[want.power_state] = 1'b1;
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count,
                             input bit with_hold);
        stim_t       s;
        logic [15:0] sw;
        int          pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        s.typed = 1'b0;
        s.res   = '0;
        for (int i = 0; i < count; i++)
        begin
            // mostly well-formed state patterns with random don't-care bits,
            // some repeats so the change flag stays low, some raw noise
            sw   = 16'($urandom);
            pick = $urandom_range(99);
            if (pick < 30)
                sw = last_gen_sw;
            else if (pick < 85)
                case ($urandom_range(7))
                    0: sw = (sw & ~16'h006F) | 16'h0020;
                    1: sw = (sw & ~16'h0008) | 16'h0040;
                    2: sw = (sw & ~16'h006F) | 16'h0021;
                    3: sw = (sw & ~16'h006D) | 16'h0022;
                    4: sw = (sw & ~16'h0068) | 16'h0024;
                    5: sw = sw & ~16'h0068;
                    6: sw = sw | 16'h000F;
                    default:
                    begin
                        sw = sw | 16'h0008;
                        if (&sw[2:0])
                            sw[4'($urandom_range(2))] = 1'b0;
                    end
                endcase
            last_gen_sw = sw;

            s.it.status_word         = sw;
            s.it.mode_display_code   = $urandom_range(1) ? 8'($urandom_range(15) - 2)
                                                         : 8'($urandom);
            s.it.target_power        = 2'($urandom_range(3));
            s.it.fault_reset_request = ($urandom_range(99) < 25);
            s.it.target_mode         = ($urandom_range(3) == 0) ? 4'($urandom)
                                                                : 4'($urandom_range(10));
            s.it.extra_control_bits  = 9'($urandom);
            send_item(s);
            if (with_hold && i == 20)
                hold_request = 1'b1;
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = 64;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                result_ch.ready = 1'b0;
                hold_left--;
            end
            else
                result_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic cmp_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        dpsc_pkg::result_t want;
        dpsc_pkg::result_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            results_seen++;
            if (ctrl_expect_q.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                mismatches++;
            end
            else
            begin
                want = ctrl_expect_q.pop_front();
                cmp_field("control_word", want.control_word, got.control_word);
                cmp_field("mode_select_code", 16'(want.mode_select_code),
                          16'(got.mode_select_code));
                cmp_field("power_state", 16'(want.power_state), 16'(got.power_state));
                cmp_field("power_state_changed", 16'(want.power_state_changed),
                          16'(got.power_state_changed));
                cmp_field("actual_mode", 16'(want.actual_mode), 16'(got.actual_mode));
                cmp_field("has_fault", 16'(want.has_fault), 16'(got.has_fault));
                cmp_field("has_warning", 16'(want.has_warning), 16'(got.has_warning));
                cmp_field("voltage_enabled", 16'(want.voltage_enabled),
                          16'(got.voltage_enabled));
                cmp_field("remote_active", 16'(want.remote_active), 16'(got.remote_active));
                cmp_field("internal_limit", 16'(want.internal_limit),
                          16'(got.internal_limit));
                cmp_field("specific_status_bits", 16'(want.specific_status_bits),
                          16'(got.specific_status_bits));
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;

        // typed rows: after reset, all-ones extremes, pulse then busy beat, fault decode
        add_row(mk_item(16'h0020, 8'sh00, dpsc_pkg::TGT_DISABLED, 1'b0, 4'd0, 9'h000), 1'b1,
                mk_res(16'h0004, 4'd0, dpsc_pkg::PS_NOT_READY, 1'b0, 4'd0, 5'b00000, 6'h00));
        add_row(mk_item(16'hFFFF, 8'sh7F, TGT_HOLD, 1'b1, 4'd15, 9'h1FF), 1'b1,
                mk_res(16'hFAF0, 4'd0, dpsc_pkg::PS_FAULT_REACTION, 1'b1, 4'd0, 5'b11111,
                       6'h3F));
        add_row(mk_item(16'hFFFF, 8'sh80, dpsc_pkg::TGT_DISABLED, 1'b1, 4'd10, 9'h000), 1'b1,
                mk_res(16'h0004, 4'd11, dpsc_pkg::PS_FAULT_REACTION, 1'b0, 4'd0, 5'b11111,
                       6'h3F));
        add_row(mk_item(16'h0008, 8'sh0B, dpsc_pkg::TGT_ENABLED, 1'b0, 4'd4, 9'h000), 1'b1,
                mk_res(16'h0086, 4'd4, dpsc_pkg::PS_FAULT, 1'b1, 4'd10, 5'b10000, 6'h00));
        add_row(mk_item(16'h0008, 8'sh05, dpsc_pkg::TGT_QUICKSTOP, 1'b0, 4'd5, 9'h000), 1'b1,
                mk_res(16'h0006, 4'd6, dpsc_pkg::PS_FAULT, 1'b0, 4'd0, 5'b10000, 6'h00));
        // walk the states under each target, with odd mode codes
        add_row(mk_item(16'h0040, 8'sh06, dpsc_pkg::TGT_ENABLED, 1'b1, 4'd11, 9'h001),
                1'b0, '0);
        add_row(mk_item(16'h0021, 8'shFF, dpsc_pkg::TGT_ENABLED, 1'b1, 4'd7, 9'h100),
                1'b0, '0);
        add_row(mk_item(16'h0023, 8'sh0C, dpsc_pkg::TGT_ENABLED, 1'b0, 4'd1, 9'h0AA),
                1'b0, '0);
        add_row(mk_item(16'h0027, 8'sh01, dpsc_pkg::TGT_QUICKSTOP, 1'b0, 4'd2, 9'h155),
                1'b0, '0);
        add_row(mk_item(16'h0007, 8'sh04, dpsc_pkg::TGT_QUICKSTOP, 1'b0, 4'd3, 9'h000),
                1'b0, '0);
        add_row(mk_item(16'h0007, 8'sh07, dpsc_pkg::TGT_ENABLED, 1'b1, 4'd6, 9'h000),
                1'b0, '0);
        add_row(mk_item(16'h0027, 8'sh08, dpsc_pkg::TGT_DISABLED, 1'b0, 4'd8, 9'h000),
                1'b0, '0);
        add_row(mk_item(16'h0023, 8'sh09, dpsc_pkg::TGT_DISABLED, 1'b0, 4'd9, 9'h000),
                1'b0, '0);
        add_row(mk_item(16'h0021, 8'sh0A, dpsc_pkg::TGT_DISABLED, 1'b0, 4'd12, 9'h000),
                1'b0, '0);
        add_row(mk_item(16'h0040, 8'sh02, dpsc_pkg::TGT_QUICKSTOP, 1'b0, 4'd13, 9'h000),
                1'b0, '0);
        add_row(mk_item(16'h0020, 8'sh03, dpsc_pkg::TGT_ENABLED, 1'b0, 4'd14, 9'h000),
                1'b0, '0);
        add_row(mk_item(16'h0020, 8'sh0D, dpsc_pkg::TGT_QUICKSTOP, 1'b0, 4'd0, 9'h000),
                1'b0, '0);
        add_row(mk_item(16'h000F, 8'sh81, dpsc_pkg::TGT_ENABLED, 1'b0, 4'd10, 9'h000),
                1'b0, '0);
        add_row(mk_item(16'hAA80, 8'sh00, TGT_HOLD, 1'b0, 4'd0, 9'h0F0), 1'b0, '0);
        add_row(mk_item(16'h5500, 8'sh00, TGT_HOLD, 1'b0, 4'd0, 9'h00F), 1'b0, '0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_table[i])
            send_item(stim_table[i]);

        run_phase(0, 0, 240, 1'b1);
        run_phase(58, 0, 240, 1'b0);
        run_phase(0, 58, 240, 1'b0);
        run_phase(31, 31, 240, 1'b0);

        @(negedge clk);
        item_ch.valid = 1'b0;
        while (ctrl_expect_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("sent %0d status beats, checked %0d result beats, %0d fault-reset pulses",
                 items_sent, results_seen, pulses_seen);
        $display("power states reached (bit per state): %b, %0d state changes flagged",
                 states_reached, changes_seen);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== drive_power_state_control_core.f =====
rtl/core/dpsc_pkg.sv
rtl/core/dpsc_in_if.sv
rtl/core/dpsc_out_if.sv
rtl/core/drive_power_state_control_core.sv
tb/sv/testbench.sv
